// ===== design/cau_pkg.sv =====
// Shared constants and operation codes for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_WIDTH_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int MODE_WIDTH        = 3;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_MOD = 3'd4
    } mode_t;

endpackage

// ===== design/complex_arithmetic_unit.sv =====
// Pipelined complex add, subtract, multiply, divide and modulus in signed fixed point.
// Stages: operands, products, sign/magnitude, divider/root, output (Q8.8 default).
// Throughput: one transaction per cycle unless the output stalls; each divider stage
// retires a quotient bit, the modulus square root one root bit per stage of the chain.
// A stall on the output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears every valid bit; payload is not reset.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
    parameter int DATA_WIDTH    = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cau_pkg::MODE_WIDTH-1:0]   mode,
    input  logic signed [DATA_WIDTH-1:0]     a_real,
    input  logic signed [DATA_WIDTH-1:0]     a_imag,
    input  logic signed [DATA_WIDTH-1:0]     b_real,
    input  logic signed [DATA_WIDTH-1:0]     b_imag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [DATA_WIDTH-1:0]     result_real,
    output logic signed [DATA_WIDTH-1:0]     result_imag,
    output logic                             divide_by_zero,
    output logic                             overflow
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = PW + FRACTION_BITS;
    localparam int RW = PW + 1;
    localparam int MW = NW + 1;
    localparam int SW = W + 3;

    typedef struct packed {
        cau_pkg::mode_t      mode;
        logic                dz;
        logic                neg_re;
        logic                neg_im;
        logic [MW-1:0]       fin_re;
        logic [MW-1:0]       fin_im;
        logic [PW-1:0]       den;
        logic [RW-1:0]       a_re;
        logic [NW-1:0]       q_re;
        logic [RW-1:0]       a_im;
        logic [NW-1:0]       q_im;
        logic [SW-1:0]       sq_rem;
        logic [W-1:0]        sq_root;
    } work_t;

    logic en;

    // stage 0: operand registers
    logic                              v0_reg;
    cau_pkg::mode_t                    mode0_reg;
    logic signed [W-1:0]               ar_reg, ai_reg, br_reg, bi_reg;

    // stage 1: products and plain sums
    logic                              v1_reg;
    cau_pkg::mode_t                    mode1_reg;
    logic signed [PW-1:0]              p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic signed [PW-1:0]              p_brbr_reg, p_bibi_reg, p_arar_reg, p_aiai_reg;
    logic signed [W:0]                 s_re_reg, s_im_reg;

    // divider and root stages
    logic                              wv_reg [0:NW];
    work_t                             w_reg  [0:NW];
    work_t                             init_next;

    // output register
    logic                              out_valid_reg;
    logic signed [W-1:0]               res_re_reg, res_im_reg;
    logic                              dz_reg, ovf_reg;
    logic signed [W-1:0]               res_re_next, res_im_next;
    logic                              ovf_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode0_reg  <= cau_pkg::mode_t'(mode);
            ar_reg     <= a_real;
            ai_reg     <= a_imag;
            br_reg     <= b_real;
            bi_reg     <= b_imag;
            mode1_reg  <= mode0_reg;
            p_arbr_reg <= ar_reg * br_reg;
            p_aibi_reg <= ai_reg * bi_reg;
            p_arbi_reg <= ar_reg * bi_reg;
            p_aibr_reg <= ai_reg * br_reg;
            p_brbr_reg <= br_reg * br_reg;
            p_bibi_reg <= bi_reg * bi_reg;
            p_arar_reg <= ar_reg * ar_reg;
            p_aiai_reg <= ai_reg * ai_reg;
            if (mode0_reg == cau_pkg::MODE_SUB)
            begin
                s_re_reg <= (W+1)'(ar_reg) - (W+1)'(br_reg);
                s_im_reg <= (W+1)'(ai_reg) - (W+1)'(bi_reg);
            end
            else
            begin
                s_re_reg <= (W+1)'(ar_reg) + (W+1)'(br_reg);
                s_im_reg <= (W+1)'(ai_reg) + (W+1)'(bi_reg);
            end
        end
    end

    // stage 2: combine products into sign/magnitude form
    logic signed [PW:0] sum_re, sum_im;
    logic        [PW:0] abs_re, abs_im;

    always_comb
    begin
        init_next      = '0;
        init_next.mode = mode1_reg;
        case (mode1_reg)
            cau_pkg::MODE_MUL:
            begin
                sum_re = (PW+1)'(p_arbr_reg) - (PW+1)'(p_aibi_reg);
                sum_im = (PW+1)'(p_arbi_reg) + (PW+1)'(p_aibr_reg);
            end
            cau_pkg::MODE_DIV:
            begin
                sum_re = (PW+1)'(p_arbr_reg) + (PW+1)'(p_aibi_reg);
                sum_im = (PW+1)'(p_aibr_reg) - (PW+1)'(p_arbi_reg);
            end
            default:
            begin
                sum_re = (PW+1)'(s_re_reg);
                sum_im = (PW+1)'(s_im_reg);
            end
        endcase
        abs_re = sum_re[PW] ? (PW+1)'(-sum_re) : (PW+1)'(sum_re);
        abs_im = sum_im[PW] ? (PW+1)'(-sum_im) : (PW+1)'(sum_im);
        init_next.neg_re = sum_re[PW];
        init_next.neg_im = sum_im[PW];
        case (mode1_reg)
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB:
            begin
                init_next.fin_re = MW'(abs_re);
                init_next.fin_im = MW'(abs_im);
            end
            cau_pkg::MODE_MUL:
            begin
                // truncate toward zero on the magnitude
                init_next.fin_re = MW'(abs_re >> FRACTION_BITS);
                init_next.fin_im = MW'(abs_im >> FRACTION_BITS);
            end
            cau_pkg::MODE_DIV:
            begin
                init_next.den  = PW'(p_brbr_reg) + PW'(p_bibi_reg);
                init_next.dz   = (init_next.den == '0);
                init_next.q_re = NW'(abs_re[PW-1:0]) << FRACTION_BITS;
                init_next.q_im = NW'(abs_im[PW-1:0]) << FRACTION_BITS;
            end
            cau_pkg::MODE_MOD:
            begin
                init_next.neg_re = 1'b0;
                init_next.neg_im = 1'b0;
                init_next.q_re   = NW'(PW'(p_arar_reg) + PW'(p_aiai_reg)) << FRACTION_BITS;
            end
            default:
            begin
                init_next.neg_re = 1'b0;
                init_next.neg_im = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg[0] <= 1'b0;
        else if (en)
            wv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg[0] <= init_next;
    end

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_step
            work_t         w_next;
            logic [RW-1:0] sh_re, sh_im;
            logic [SW-1:0] sq_sh, sq_trial;

            always_comb
            begin
                w_next   = w_reg[k];
                sh_re    = {w_reg[k].a_re[RW-2:0], w_reg[k].q_re[NW-1]};
                sh_im    = {w_reg[k].a_im[RW-2:0], w_reg[k].q_im[NW-1]};
                sq_sh    = {w_reg[k].sq_rem[SW-3:0], w_reg[k].q_re[NW-1:NW-2]};
                sq_trial = {1'b0, w_reg[k].sq_root, 2'b01};
                if (w_reg[k].mode == cau_pkg::MODE_DIV)
                begin
                    // restoring division, one quotient bit per stage
                    if (sh_re >= RW'(w_reg[k].den))
                    begin
                        w_next.a_re = sh_re - RW'(w_reg[k].den);
                        w_next.q_re = {w_reg[k].q_re[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        w_next.a_re = sh_re;
                        w_next.q_re = {w_reg[k].q_re[NW-2:0], 1'b0};
                    end
                    if (sh_im >= RW'(w_reg[k].den))
                    begin
                        w_next.a_im = sh_im - RW'(w_reg[k].den);
                        w_next.q_im = {w_reg[k].q_im[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        w_next.a_im = sh_im;
                        w_next.q_im = {w_reg[k].q_im[NW-2:0], 1'b0};
                    end
                end
                else if (w_reg[k].mode == cau_pkg::MODE_MOD && k < W)
                begin
                    // digit-by-digit square root, two radicand bits per stage
                    w_next.q_re = w_reg[k].q_re << 2;
                    if (sq_sh >= sq_trial)
                    begin
                        w_next.sq_rem  = sq_sh - sq_trial;
                        w_next.sq_root = {w_reg[k].sq_root[W-2:0], 1'b1};
                    end
                    else
                    begin
                        w_next.sq_rem  = sq_sh;
                        w_next.sq_root = {w_reg[k].sq_root[W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    wv_reg[k+1] <= 1'b0;
                else if (en)
                    wv_reg[k+1] <= wv_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    w_reg[k+1] <= w_next;
            end
        end
    endgenerate

    // final stage: select, saturate, drive
    work_t         wf;
    logic [MW-1:0] mag_re, mag_im, lim_re, lim_im, sat_re, sat_im;

    always_comb
    begin
        wf = w_reg[NW];
        case (wf.mode)
            cau_pkg::MODE_DIV:
            begin
                mag_re = MW'(wf.q_re);
                mag_im = MW'(wf.q_im);
            end
            cau_pkg::MODE_MOD:
            begin
                mag_re = MW'(wf.sq_root);
                mag_im = '0;
            end
            default:
            begin
                mag_re = wf.fin_re;
                mag_im = wf.fin_im;
            end
        endcase
        if (wf.dz)
        begin
            mag_re = '0;
            mag_im = '0;
        end
        lim_re   = wf.neg_re ? (MW'(1) << (W-1)) : ((MW'(1) << (W-1)) - MW'(1));
        lim_im   = wf.neg_im ? (MW'(1) << (W-1)) : ((MW'(1) << (W-1)) - MW'(1));
        sat_re   = (mag_re > lim_re) ? lim_re : mag_re;
        sat_im   = (mag_im > lim_im) ? lim_im : mag_im;
        ovf_next = (mag_re > lim_re) || (mag_im > lim_im);
        res_re_next = wf.neg_re ? W'(-sat_re[W-1:0]) : W'(sat_re[W-1:0]);
        res_im_next = wf.neg_im ? W'(-sat_im[W-1:0]) : W'(sat_im[W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= wv_reg[NW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dz_reg     <= wf.dz;
            ovf_reg    <= ovf_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_real    = res_re_reg;
    assign result_imag    = res_im_reg;
    assign divide_by_zero = dz_reg;
    assign overflow       = ovf_reg;

endmodule

// ===== design/cau_checker.sv =====
// Port-level checker for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module cau_checker #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] result_real,
    input logic [DATA_WIDTH-1:0] result_imag,
    input logic                  divide_by_zero,
    input logic                  overflow
);

    // a zero divisor gives a clean zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_real == '0 && result_imag == '0 && !overflow)
        else $error("divide by zero result not zero");

    // hold the output transaction while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_real) && $stable(result_imag))
        else $error("output changed under stall");

    // input side blocks only while an output transaction waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output stall");

    // output holds flags while stalled
    a_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(divide_by_zero) && $stable(overflow))
        else $error("flags changed under stall");

    // an offered input transaction stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped before acceptance");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_real    (result_real),
    .result_imag    (result_imag),
    .divide_by_zero (divide_by_zero),
    .overflow       (overflow)
);
